// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the statistics block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/rmra_pkg.sv -----
// ----------------------------------------------------------------------------
// rmra_pkg
// Widths, step counts and types shared by the record statistics block.
// ----------------------------------------------------------------------------
package rmra_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int SUM_W           = 29;
  localparam int SQ_W            = 43;
  localparam int CNT_W           = 13;
  localparam int OUT_W           = 24;
  localparam int MAX_SAMPLES_DEF = 4096;

  // Products n*Q, S*S and n*n all fit below 2^57.
  localparam int PROD_W     = 57;
  localparam int NN_W       = 2 * CNT_W;
  localparam int MEAN_FRAC  = 8;
  localparam int VAR_SHIFT  = 17;
  localparam int DIVIDEND_W = PROD_W + VAR_SHIFT;
  localparam int QUOT_W     = 64;
  localparam int ROOT_W     = QUOT_W / 2;
  localparam int STEP_W     = $clog2(SUM_W);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_T1_LOAD,
    ST_T1_RUN,
    ST_T2_LOAD,
    ST_T2_RUN,
    ST_NN_LOAD,
    ST_NN_RUN,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_AMP_GO,
    ST_AMP_WAIT,
    ST_RMS_GO,
    ST_RMS_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ----- rtl/rmra_if.sv -----
// ----------------------------------------------------------------------------
// rmra interfaces
// Valid/ready channels for samples in and record statistics out.
// ----------------------------------------------------------------------------
interface rmra_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmra_pkg::SAMPLE_W-1:0] sample;
  logic                                 last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface

interface rmra_stats_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmra_pkg::OUT_W-1:0] mean_q8;
  logic        [rmra_pkg::OUT_W-1:0] rms_q8;
  logic        [rmra_pkg::OUT_W-1:0] amplitude_q8;
  logic        [rmra_pkg::CNT_W-1:0] sample_count;
  logic                              too_long;

  modport source (output valid, mean_q8, rms_q8, amplitude_q8, sample_count, too_long,
                  input ready);
  modport sink (input valid, mean_q8, rms_q8, amplitude_q8, sample_count, too_long,
                output ready);
endinterface

// ----- rtl/record_mean_rms_amplitude.sv -----
// ----------------------------------------------------------------------------
// record_mean_rms_amplitude
// Mean, RMS about the mean and amplitude of a record of signed samples.
// ----------------------------------------------------------------------------
// Samples of one record arrive on the samples channel, the final one marked
// by last_sample. A sample that is used is taken and then given a bit-serial
// square, which adds one shifted copy of the magnitude into the sum of
// squares per cycle. A sample beyond MAX_SAMPLES is dropped and sets
// too_long. After the marked sample the block runs three shift-add products
// (n*Q, S*S, n*n), two restoring divisions (mean, variance) and two square
// roots, with load, start and done states around them, while samples.ready
// stays low. The result then sits in an output register, so the next record
// can start while it waits to be taken. A further result waits in the last
// state, with the input stalled, until the output register frees up. All
// outputs are exact integers: the mean truncated toward zero and the RMS and
// amplitude floored, each with 8 fraction bits.
// ----------------------------------------------------------------------------
module record_mean_rms_amplitude #(
  parameter int MAX_SAMPLES = rmra_pkg::MAX_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  rmra_sample_if.sink         samples,
  rmra_stats_if.source        stats
);

  localparam int SUM_W  = rmra_pkg::SUM_W;
  localparam int SQ_W   = rmra_pkg::SQ_W;
  localparam int CNT_W  = rmra_pkg::CNT_W;
  localparam int OUT_W  = rmra_pkg::OUT_W;
  localparam int PROD_W = rmra_pkg::PROD_W;
  localparam int NN_W   = rmra_pkg::NN_W;
  localparam int SMP_W  = rmra_pkg::SAMPLE_W;
  localparam int STEP_W = rmra_pkg::STEP_W;

  rmra_pkg::state_t state;
  rmra_pkg::state_t state_next;

  logic [SUM_W-1:0]  running_sum;
  logic [SQ_W-1:0]   running_square_sum;
  logic [CNT_W-1:0]  samples_seen;
  logic              dropped_flag;
  logic              last_pending;

  logic [PROD_W-1:0] mul_a;
  logic [SUM_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0] mul_add;
  logic [STEP_W-1:0] step;

  logic [PROD_W-1:0]           spread;
  logic [NN_W-1:0]             nn;
  logic [OUT_W-1:0]            mean;
  logic [rmra_pkg::QUOT_W-1:0] var_q;
  logic [OUT_W-1:0]            amp;
  logic [OUT_W-1:0]            rms;

  logic              out_valid;
  logic [OUT_W-1:0]  out_mean;
  logic [OUT_W-1:0]  out_rms;
  logic [OUT_W-1:0]  out_amp;
  logic [CNT_W-1:0]  out_count;
  logic              out_too_long;

  logic              take;
  logic              room;
  logic [SUM_W-1:0]  sample_ext;
  logic [SMP_W-1:0]  sample_mag;
  logic              sum_neg;
  logic [SUM_W-1:0]  sum_mag;
  logic              square_last;
  logic              mul_last;
  logic              result_free;
  logic              result_load;
  logic              empty;
  logic [OUT_W-1:0]  mean_quot;

  logic                            div_start;
  logic [rmra_pkg::DIVIDEND_W-1:0] div_dividend;
  logic [NN_W-1:0]                 div_divisor;
  logic [rmra_pkg::QUOT_W-1:0]     div_quot;
  rmra_pkg::unit_sts_t             div_sts;

  logic                            sqrt_start;
  logic [rmra_pkg::QUOT_W-1:0]     sqrt_radicand;
  logic [rmra_pkg::ROOT_W-1:0]     sqrt_root;
  rmra_pkg::unit_sts_t             sqrt_sts;

  assign take        = samples.valid && samples.ready;
  assign room        = 32'(samples_seen) < 32'(MAX_SAMPLES);
  assign sample_ext  = {{(SUM_W - SMP_W){samples.sample[SMP_W-1]}}, samples.sample};
  assign sample_mag  = samples.sample[SMP_W-1] ? (~samples.sample + 1'b1) : samples.sample;
  assign sum_neg     = running_sum[SUM_W-1];
  assign sum_mag     = sum_neg ? (~running_sum + 1'b1) : running_sum;
  assign mul_add     = mul_b[0] ? mul_a : '0;
  assign square_last = step == STEP_W'(SMP_W - 1);
  assign mul_last    = step == STEP_W'(SUM_W - 1);
  assign result_free = !out_valid || stats.ready;
  assign empty       = samples_seen == '0;
  assign mean_quot   = div_quot[OUT_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rmra_pkg::ST_IDLE: begin
        if (take) begin
          if (room) begin
            state_next = rmra_pkg::ST_SQUARE;
          end else if (samples.last_sample) begin
            state_next = rmra_pkg::ST_T1_LOAD;
          end
        end
      end
      rmra_pkg::ST_SQUARE: begin
        if (square_last) begin
          state_next = last_pending ? rmra_pkg::ST_T1_LOAD : rmra_pkg::ST_IDLE;
        end
      end
      rmra_pkg::ST_T1_LOAD: state_next = rmra_pkg::ST_T1_RUN;
      rmra_pkg::ST_T1_RUN: begin
        if (mul_last) state_next = rmra_pkg::ST_T2_LOAD;
      end
      rmra_pkg::ST_T2_LOAD: state_next = rmra_pkg::ST_T2_RUN;
      rmra_pkg::ST_T2_RUN: begin
        if (mul_last) state_next = rmra_pkg::ST_NN_LOAD;
      end
      rmra_pkg::ST_NN_LOAD: state_next = rmra_pkg::ST_NN_RUN;
      rmra_pkg::ST_NN_RUN: begin
        if (mul_last) state_next = rmra_pkg::ST_MEAN_GO;
      end
      rmra_pkg::ST_MEAN_GO: state_next = rmra_pkg::ST_MEAN_WAIT;
      rmra_pkg::ST_MEAN_WAIT: begin
        if (div_sts.done) state_next = rmra_pkg::ST_VAR_GO;
      end
      rmra_pkg::ST_VAR_GO: state_next = rmra_pkg::ST_VAR_WAIT;
      rmra_pkg::ST_VAR_WAIT: begin
        if (div_sts.done) state_next = rmra_pkg::ST_AMP_GO;
      end
      rmra_pkg::ST_AMP_GO: state_next = rmra_pkg::ST_AMP_WAIT;
      rmra_pkg::ST_AMP_WAIT: begin
        if (sqrt_sts.done) state_next = rmra_pkg::ST_RMS_GO;
      end
      rmra_pkg::ST_RMS_GO: state_next = rmra_pkg::ST_RMS_WAIT;
      rmra_pkg::ST_RMS_WAIT: begin
        if (sqrt_sts.done) state_next = rmra_pkg::ST_DONE;
      end
      rmra_pkg::ST_DONE: begin
        if (result_free) state_next = rmra_pkg::ST_IDLE;
      end
      default: state_next = rmra_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    samples.ready = 1'b0;
    div_start     = 1'b0;
    sqrt_start    = 1'b0;
    result_load   = 1'b0;
    case (state)
      rmra_pkg::ST_IDLE:    samples.ready = 1'b1;
      rmra_pkg::ST_MEAN_GO: div_start     = 1'b1;
      rmra_pkg::ST_VAR_GO:  div_start     = 1'b1;
      rmra_pkg::ST_AMP_GO:  sqrt_start    = 1'b1;
      rmra_pkg::ST_RMS_GO:  sqrt_start    = 1'b1;
      rmra_pkg::ST_DONE:    result_load   = result_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Record accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum        <= '0;
      running_square_sum <= '0;
      samples_seen       <= '0;
      dropped_flag       <= 1'b0;
      last_pending       <= 1'b0;
    end else if (result_load) begin
      running_sum        <= '0;
      running_square_sum <= '0;
      samples_seen       <= '0;
      dropped_flag       <= 1'b0;
    end else begin
      if (take) begin
        last_pending <= samples.last_sample;
        if (room) begin
          running_sum  <= running_sum + sample_ext;
          samples_seen <= samples_seen + 1'b1;
        end else begin
          dropped_flag <= 1'b1;
        end
      end
      if (state == rmra_pkg::ST_SQUARE) begin
        running_square_sum <= running_square_sum + mul_add[SQ_W-1:0];
      end
    end
  end

  // Shared shift-add multiplier and the end-of-record datapath.
  always_ff @(posedge clk) begin
    case (state)
      rmra_pkg::ST_IDLE: begin
        if (take) begin
          mul_a <= PROD_W'(sample_mag);
          mul_b <= SUM_W'(sample_mag);
          step  <= '0;
        end
      end
      rmra_pkg::ST_SQUARE, rmra_pkg::ST_T1_RUN, rmra_pkg::ST_T2_RUN,
      rmra_pkg::ST_NN_RUN: begin
        mul_a <= mul_a << 1;
        mul_b <= mul_b >> 1;
        mul_p <= mul_p + mul_add;
        step  <= step + 1'b1;
      end
      rmra_pkg::ST_T1_LOAD: begin
        mul_a <= PROD_W'(running_square_sum);
        mul_b <= SUM_W'(samples_seen);
        mul_p <= '0;
        step  <= '0;
      end
      rmra_pkg::ST_T2_LOAD: begin
        spread <= mul_p;
        mul_a  <= PROD_W'(sum_mag);
        mul_b  <= sum_mag;
        mul_p  <= '0;
        step   <= '0;
      end
      rmra_pkg::ST_NN_LOAD: begin
        // A negative spread can only come from wrapped sums; clamp it.
        spread <= (spread > mul_p) ? (spread - mul_p) : '0;
        mul_a  <= PROD_W'(samples_seen);
        mul_b  <= SUM_W'(samples_seen);
        mul_p  <= '0;
        step   <= '0;
      end
      rmra_pkg::ST_MEAN_GO: nn <= mul_p[NN_W-1:0];
      rmra_pkg::ST_MEAN_WAIT: begin
        if (div_sts.done) mean <= sum_neg ? (~mean_quot + 1'b1) : mean_quot;
      end
      rmra_pkg::ST_VAR_WAIT: begin
        if (div_sts.done) var_q <= div_quot;
      end
      rmra_pkg::ST_AMP_WAIT: begin
        if (sqrt_sts.done) amp <= sqrt_root[OUT_W-1:0];
      end
      rmra_pkg::ST_RMS_WAIT: begin
        if (sqrt_sts.done) rms <= sqrt_root[OUT_W-1:0];
      end
      default: ;
    endcase
  end

  // The divider first gives |S|*256/n, then the spread scaled by 2^17 over n*n.
  assign div_dividend = (state == rmra_pkg::ST_MEAN_GO) ?
                        rmra_pkg::DIVIDEND_W'({sum_mag, {rmra_pkg::MEAN_FRAC{1'b0}}}) :
                        {spread, {rmra_pkg::VAR_SHIFT{1'b0}}};
  assign div_divisor  = (state == rmra_pkg::ST_MEAN_GO) ? NN_W'(samples_seen) : nn;

  // The RMS radicand is half the amplitude radicand, floored.
  assign sqrt_radicand = (state == rmra_pkg::ST_AMP_GO) ? var_q :
                         {1'b0, var_q[rmra_pkg::QUOT_W-1:1]};

  rmra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .sts      (div_sts)
  );

  rmra_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_radicand),
    .root     (sqrt_root),
    .sts      (sqrt_sts)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (stats.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_mean     <= empty ? '0 : mean;
      out_rms      <= empty ? '0 : rms;
      out_amp      <= empty ? '0 : amp;
      out_count    <= samples_seen;
      out_too_long <= dropped_flag;
    end
  end

  assign stats.valid        = out_valid;
  assign stats.mean_q8      = out_mean;
  assign stats.rms_q8       = out_rms;
  assign stats.amplitude_q8 = out_amp;
  assign stats.sample_count = out_count;
  assign stats.too_long     = out_too_long;

endmodule

// ----- rtl/rmra_div.sv -----
// ----------------------------------------------------------------------------
// rmra_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmra_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [rmra_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [rmra_pkg::NN_W-1:0]           divisor,
  output logic [rmra_pkg::QUOT_W-1:0]         quot,
  output rmra_pkg::unit_sts_t                 sts
);

  localparam int CW = $clog2(rmra_pkg::DIVIDEND_W);
  localparam logic [CW-1:0] LAST = CW'(rmra_pkg::DIVIDEND_W - 1);

  logic                            busy;
  logic                            done;
  logic [CW-1:0]                   count;
  logic [rmra_pkg::DIVIDEND_W-1:0] num;
  logic [rmra_pkg::NN_W-1:0]       den;
  logic [rmra_pkg::NN_W-1:0]       rem;
  logic [rmra_pkg::NN_W:0]         shifted;
  logic [rmra_pkg::NN_W:0]         diff;
  logic                            ge;

  assign shifted = {rem, num[rmra_pkg::DIVIDEND_W-1]};
  assign ge      = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == LAST);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == LAST)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num   <= dividend;
      den   <= divisor;
      rem   <= '0;
      count <= '0;
    end else if (busy) begin
      num   <= num << 1;
      rem   <= ge ? diff[rmra_pkg::NN_W-1:0] : shifted[rmra_pkg::NN_W-1:0];
      quot  <= {quot[rmra_pkg::QUOT_W-2:0], ge};
      count <= count + 1'b1;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ----- rtl/rmra_sqrt.sv -----
// ----------------------------------------------------------------------------
// rmra_sqrt
// Integer square root, floor, one root bit per cycle.
// ----------------------------------------------------------------------------
module rmra_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rmra_pkg::QUOT_W-1:0]     radicand,
  output logic [rmra_pkg::ROOT_W-1:0]     root,
  output rmra_pkg::unit_sts_t             sts
);

  localparam int CW = $clog2(rmra_pkg::ROOT_W);
  localparam int RW = rmra_pkg::ROOT_W + 2;
  localparam int TW = rmra_pkg::ROOT_W + 4;
  localparam logic [CW-1:0] LAST = CW'(rmra_pkg::ROOT_W - 1);

  logic                        busy;
  logic                        done;
  logic [CW-1:0]               count;
  logic [rmra_pkg::QUOT_W-1:0] rad;
  logic [RW-1:0]               rem;
  logic [TW-1:0]               partial;
  logic [TW-1:0]               trial;
  logic [TW-1:0]               diff;
  logic                        ge;

  // Bring down the next two radicand bits and try root*4 + 1.
  assign partial = {rem, rad[rmra_pkg::QUOT_W-1 -: 2]};
  assign trial   = TW'({root, 2'b01});
  assign ge      = partial >= trial;
  assign diff    = partial - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == LAST);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == LAST)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad   <= radicand;
      rem   <= '0;
      root  <= '0;
      count <= '0;
    end else if (busy) begin
      rad   <= rad << 2;
      rem   <= ge ? diff[RW-1:0] : partial[RW-1:0];
      root  <= {root[rmra_pkg::ROOT_W-2:0], ge};
      count <= count + 1'b1;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ----- rtl/rmra_checker.sv -----
// ----------------------------------------------------------------------------
// rmra_checker
// Port-level checks on the record statistics block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmra_checker #(
  parameter int MAX_SAMPLES = rmra_pkg::MAX_SAMPLES_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rmra_pkg::OUT_W-1:0] out_mean,
  input logic [rmra_pkg::OUT_W-1:0] out_rms,
  input logic [rmra_pkg::OUT_W-1:0] out_amp,
  input logic [rmra_pkg::CNT_W-1:0] out_count,
  input logic                       out_too_long
);

  // A stalled result must stay put until it is taken.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_mean) && $stable(out_rms) && $stable(out_amp) && $stable(out_count))

  // The marked sample starts the end-of-record work, so no sample follows at once.
  `ASSERT_NEXT(a_last_blocks, in_valid && in_ready && in_last, !in_ready)

  // The count never passes the record limit.
  `ASSERT_NOW(a_count_max, out_valid, 32'(out_count) <= 32'(MAX_SAMPLES))

  // Samples are only dropped once the record is full.
  `ASSERT_NOW(a_drop_full, out_valid && out_too_long, 32'(out_count) == 32'(MAX_SAMPLES))

endmodule

bind record_mean_rms_amplitude rmra_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_rmra_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .in_last      (samples.last_sample),
  .out_valid    (stats.valid),
  .out_ready    (stats.ready),
  .out_mean     (stats.mean_q8),
  .out_rms      (stats.rms_q8),
  .out_amp      (stats.amplitude_q8),
  .out_count    (stats.sample_count),
  .out_too_long (stats.too_long)
);

// ----- tb/record_mean_rms_amplitude_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_mean_rms_amplitude_tb
// Self-checking bench for the record mean, RMS and amplitude block.
// Records of signed samples go in with random gaps while the result side
// stalls at random. An exact integer predictor works out each record's
// statistics, and every result transaction is compared with the oldest one.
// ----------------------------------------------------------------------------
module record_mean_rms_amplitude_tb;

  localparam int SAMPLE_W      = rmra_pkg::SAMPLE_W;
  localparam int SUM_W         = rmra_pkg::SUM_W;
  localparam int SQ_W          = rmra_pkg::SQ_W;
  localparam int CNT_W         = rmra_pkg::CNT_W;
  localparam int OUT_W         = rmra_pkg::OUT_W;
  localparam int MAX_SAMPLES   = rmra_pkg::MAX_SAMPLES_DEF;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 500;
  localparam int HOLD_CYCLES   = 4000;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    logic [OUT_W-1:0] mean_q8;
    logic [OUT_W-1:0] rms_q8;
    logic [OUT_W-1:0] amplitude_q8;
    logic [CNT_W-1:0] sample_count;
    logic             too_long;
  } record_stats_t;

  typedef enum int {MIX_FULL, MIX_SMALL, MIX_EXTREME, MIX_OFFSET} sample_mix_t;

  class record_statistics;
    logic signed [SUM_W-1:0] sum_acc;
    logic [SQ_W-1:0]         square_acc;
    logic [CNT_W-1:0]        used_count;
    logic                    dropped;
    record_stats_t           pending_stats[$];
    int                      errors;

    function new();
      sum_acc    = '0;
      square_acc = '0;
      used_count = '0;
      dropped    = 1'b0;
      errors     = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    // Called for every accepted sample transaction.
    function void take_sample(logic signed [SAMPLE_W-1:0] x, logic last);
      longint        mag_x;
      longint        n;
      longint        s;
      longint        mean;
      logic [63:0]   mag_s;
      logic [63:0]   t1;
      logic [63:0]   t2;
      logic [63:0]   spread;
      logic [63:0]   nn;
      logic [63:0]   root;
      logic [127:0]  var_q16;
      logic [127:0]  var2_q16;
      record_stats_t want;
      if (used_count < MAX_SAMPLES) begin
        mag_x      = (x < 0) ? -longint'(x) : longint'(x);
        sum_acc    = sum_acc + x;
        square_acc = square_acc + SQ_W'(mag_x * mag_x);
        used_count = used_count + 1'b1;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;

      n = used_count;
      s = sum_acc;
      want.sample_count = used_count;
      want.too_long     = dropped;
      if (n == 0) begin
        want.mean_q8      = '0;
        want.rms_q8       = '0;
        want.amplitude_q8 = '0;
      end else begin
        mean         = (s * 256) / n;
        want.mean_q8 = mean[OUT_W-1:0];
        mag_s        = (s < 0) ? -s : s;
        t1           = n * square_acc;
        t2           = mag_s * mag_s;
        // Wrapped accumulators could make the spread negative; treat it as zero.
        spread   = (t1 > t2) ? t1 - t2 : '0;
        nn       = n * n;
        var_q16  = ({64'd0, spread} << 16) / {64'd0, nn};
        var2_q16 = ({64'd0, spread} << 17) / {64'd0, nn};
        root              = floor_sqrt(var_q16[63:0]);
        want.rms_q8       = root[OUT_W-1:0];
        root              = floor_sqrt(var2_q16[63:0]);
        want.amplitude_q8 = root[OUT_W-1:0];
      end
      pending_stats.push_back(want);

      sum_acc    = '0;
      square_acc = '0;
      used_count = '0;
      dropped    = 1'b0;
    endfunction

    // Called for every accepted result transaction.
    task compare_stats(record_stats_t got);
      record_stats_t want;
      if (pending_stats.size() == 0) begin
        report($sformatf("unexpected result: mean %0d rms %0d amp %0d count %0d too_long %0b",
                         $signed(got.mean_q8), got.rms_q8, got.amplitude_q8,
                         got.sample_count, got.too_long));
        return;
      end
      want = pending_stats.pop_front();
      if (got !== want) begin
        report($sformatf({"stats mismatch: got mean %0d rms %0d amp %0d count %0d long %0b,",
                          " expected mean %0d rms %0d amp %0d count %0d long %0b"},
                         $signed(got.mean_q8), got.rms_q8, got.amplitude_q8,
                         got.sample_count, got.too_long,
                         $signed(want.mean_q8), want.rms_q8, want.amplitude_q8,
                         want.sample_count, want.too_long));
      end
    endtask
  endclass

  logic   clk;
  logic   rst;
  int     send_idle_pct  = 25;
  int     recv_stall_pct = 25;
  bit     hold_start     = 1'b0;
  int     items_sent     = 0;
  longint cycle_count;

  rmra_sample_if samples_ch ();
  rmra_stats_if  stats_ch ();

  record_statistics board = new();

  record_mean_rms_amplitude #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_ch),
    .stats  (stats_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : stats_receiver
    int hold_left;
    hold_left      = 0;
    stats_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_left  = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        stats_ch.ready = 1'b0;
        hold_left--;
      end else begin
        stats_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : stats_monitor
    record_stats_t got;
    if (!rst && stats_ch.valid && stats_ch.ready) begin
      got = {stats_ch.mean_q8, stats_ch.rms_q8, stats_ch.amplitude_q8,
             stats_ch.sample_count, stats_ch.too_long};
      board.compare_stats(got);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_item(input logic signed [SAMPLE_W-1:0] x, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      samples_ch.valid = 1'b0;
      @(negedge clk);
    end
    samples_ch.valid       = 1'b1;
    samples_ch.sample      = x;
    samples_ch.last_sample = last;
    do @(posedge clk); while (!samples_ch.ready);
    board.take_sample(x, last);
    items_sent++;
  endtask

  // Stop offering samples until every predicted record result has arrived.
  task automatic wait_for_results();
    @(negedge clk);
    samples_ch.valid = 1'b0;
    while (board.pending_stats.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_value(
      sample_mix_t mix, logic signed [SAMPLE_W-1:0] base);
    int v;
    case (mix)
      MIX_FULL:    v = int'($urandom);
      MIX_SMALL:   v = int'($urandom_range(16)) - 8;
      MIX_EXTREME: begin
        case ($urandom_range(3))
          0:       v = SAMPLE_MIN;
          1:       v = SAMPLE_MAX;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default:     v = int'(base) + int'($urandom_range(64)) - 32;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_record(input int len, input sample_mix_t mix);
    logic signed [SAMPLE_W-1:0] base;
    base = SAMPLE_W'($urandom);
    for (int i = 0; i < len; i++) send_item(pick_value(mix, base), i == len - 1);
  endtask

  // Mostly short records, so the per-record divide and root dominate more.
  task automatic random_records(input int item_goal);
    int start_count;
    int pick;
    int len;
    start_count = items_sent;
    while (items_sent - start_count < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 65)      len = $urandom_range(8, 1);
      else if (pick < 95) len = $urandom_range(40, 9);
      else                len = $urandom_range(160, 41);
      send_record(len, sample_mix_t'($urandom_range(3)));
    end
  endtask

  initial begin : main_sequence
    samples_ch.valid       = 1'b0;
    samples_ch.sample      = '0;
    samples_ch.last_sample = 1'b0;
    rst                    = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Single-sample records at the extremes and at zero.
    send_item(SAMPLE_MAX, 1'b1);
    send_item(SAMPLE_MIN, 1'b1);
    send_item('0, 1'b1);
    // Full-scale swings give the largest RMS and amplitude.
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MAX, 1'b1);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MAX, 1'b1);
    // Negative means with a fraction must truncate toward zero, then a record of powers of two.
    send_item(-16'sd1, 1'b0);
    send_item('0, 1'b0);
    send_item('0, 1'b1);
    send_item(-16'sd1, 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(-16'sd2, 1'b1);
    send_item(16'sd1, 1'b0);
    send_item(16'sd2, 1'b0);
    send_item(16'sd4, 1'b0);
    send_item(16'sd8, 1'b0);
    send_item(16'sd16, 1'b0);
    send_item(16'sd32, 1'b1);
    wait_for_results();

    random_records(600);

    // A stretch with no gaps and no stalls on either side.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_records(300);
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    wait_for_results();

    // The result side holds off while records keep coming, so the output
    // register fills and the block has to stall its sample input.
    hold_start = 1'b1;
    for (int r = 0; r < 12; r++) send_record($urandom_range(4, 2), MIX_FULL);
    random_records(850);
    wait_for_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending_stats.size() != 0)
      board.report($sformatf("%0d record results never arrived", board.pending_stats.size()));
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
